// ----- rtl/stap_pkg.sv -----
// shared types, constants and lookup tables for the stereo tremolo / auto-pan block
`default_nettype none

package stap_pkg;

    // configuration port geometry
    localparam int CFG_ADDR_W = 4;
    localparam int PDATA_W    = 32;
    localparam int STEP_W     = 24;
    localparam int DEPTH_W    = 8;

    // sine table geometry
    localparam int SINE_ADDR_W = 8;
    localparam int SINE_DEPTH  = 1 << SINE_ADDR_W;
    localparam int DEPTH_LEVELS = 1 << DEPTH_W;

    // reset values of the registers
    localparam logic [STEP_W-1:0]  PHASE_STEP_RST = 24'd1000;
    localparam logic [DEPTH_W-1:0] DEPTH_RST      = 8'd96;

    // Q15 gains and lfo values in 18 bits, range -4 to just under +4
    typedef logic signed [17:0] gain_t;
    localparam gain_t Q15_ONE = 18'sd32768;

    // register indexes
    typedef enum logic [1:0] {
        REG_PHASE_STEP = 2'd0,
        REG_DEPTH      = 2'd1,
        REG_LFO_SHAPE  = 2'd2,
        REG_GAIN_MODE  = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        SHAPE_SINE     = 2'd0,
        SHAPE_SQUARE   = 2'd1,
        SHAPE_SAW      = 2'd2,
        SHAPE_TRIANGLE = 2'd3
    } lfo_shape_t;

    // code 3 is unused and behaves as both
    typedef enum logic [1:0] {
        MODE_TREMOLO = 2'd0,
        MODE_PAN     = 2'd1,
        MODE_BOTH    = 2'd2
    } gain_mode_t;

    typedef struct packed {
        logic [STEP_W-1:0]  phase_step;
        logic [DEPTH_W-1:0] depth;
        lfo_shape_t         lfo_shape;
        gain_mode_t         gain_mode;
    } cfg_t;

    // per-lane controls: mix enable from the sequencer, gain mode from the registers
    typedef struct packed {
        logic       mix_en;
        gain_mode_t mode;
    } lane_ctrl_t;

    typedef logic signed [15:0] sine_lut_t [SINE_DEPTH];
    typedef logic [15:0] depth_lut_t [DEPTH_LEVELS];

    // sine in Q15 from a Q30 Taylor series, evaluated at elaboration
    function automatic sine_lut_t build_sine_lut();
        sine_lut_t         lut;
        longint unsigned   u;
        longint unsigned   x;
        longint unsigned   x2;
        longint unsigned   t;
        longint unsigned   s;
        longint unsigned   r;
        bit                neg;
        for (int k = 0; k < SINE_DEPTH; k++)
        begin
            u = (64'(k) << 32) / SINE_DEPTH;
            neg = 1'b0;
            if (u >= 64'h8000_0000)
            begin
                neg = 1'b1;
                u = u - 64'h8000_0000;
            end
            if (u > 64'h4000_0000)
                u = 64'h8000_0000 - u;
            x  = (u * 64'd6746518852) >> 32;
            x2 = (x * x) >> 30;
            t  = 64'd1073741824;
            t  = 64'd1073741824 - ((x2 * t) >> 30) / 156;
            t  = 64'd1073741824 - ((x2 * t) >> 30) / 110;
            t  = 64'd1073741824 - ((x2 * t) >> 30) / 72;
            t  = 64'd1073741824 - ((x2 * t) >> 30) / 42;
            t  = 64'd1073741824 - ((x2 * t) >> 30) / 20;
            t  = 64'd1073741824 - ((x2 * t) >> 30) / 6;
            s  = (x * t) >> 30;
            r  = (s + 64'd16384) >> 15;
            if (r > 64'd32767)
                r = 64'd32767;
            lut[k] = neg ? -16'(r) : 16'(r);
        end
        return lut;
    endfunction

    // depth in Q15: round(depth * 32768 / 255)
    function automatic depth_lut_t build_depth_lut();
        depth_lut_t lut;
        for (int i = 0; i < DEPTH_LEVELS; i++)
        begin
            lut[i] = 16'((i * 32768 + 127) / 255);
        end
        return lut;
    endfunction

    localparam sine_lut_t  SINE_LUT  = build_sine_lut();
    localparam depth_lut_t DEPTH_LUT = build_depth_lut();

endpackage

`default_nettype wire

// ----- rtl/stap_if.sv -----
// sample-pair channels: input pair and output pair, valid/ready handshake
`default_nettype none

interface stap_in_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] left_in;
    logic signed [SAMPLE_WIDTH-1:0] right_in;

    modport source (output valid, output left_in, output right_in, input ready);
    modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

interface stap_out_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] left_out;
    logic signed [SAMPLE_WIDTH-1:0] right_out;

    modport source (output valid, output left_out, output right_out, input ready);
    modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

`default_nettype wire

// ----- rtl/stap_regs.sv -----
// apb register file: phase step, depth, lfo shape, gain mode
`default_nettype none

module stap_regs (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [stap_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [stap_pkg::PDATA_W-1:0] pwdata,
    output logic      [stap_pkg::PDATA_W-1:0] prdata,
    output logic                              pready,
    output stap_pkg::cfg_t                    cfg
);

    stap_pkg::cfg_t      cfg_reg;
    stap_pkg::reg_idx_t  reg_idx;
    logic                wr_en;

    assign reg_idx = stap_pkg::reg_idx_t'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.phase_step <= stap_pkg::PHASE_STEP_RST;
            cfg_reg.depth      <= stap_pkg::DEPTH_RST;
            cfg_reg.lfo_shape  <= stap_pkg::SHAPE_SINE;
            cfg_reg.gain_mode  <= stap_pkg::MODE_TREMOLO;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                stap_pkg::REG_PHASE_STEP:
                    cfg_reg.phase_step <= pwdata[stap_pkg::STEP_W-1:0];
                stap_pkg::REG_DEPTH:
                    cfg_reg.depth <= pwdata[stap_pkg::DEPTH_W-1:0];
                stap_pkg::REG_LFO_SHAPE:
                    cfg_reg.lfo_shape <= stap_pkg::lfo_shape_t'(pwdata[1:0]);
                stap_pkg::REG_GAIN_MODE:
                    cfg_reg.gain_mode <= stap_pkg::gain_mode_t'(pwdata[1:0]);
                default:
                begin
                end
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (reg_idx)
            stap_pkg::REG_PHASE_STEP:
                prdata = stap_pkg::PDATA_W'(cfg_reg.phase_step);
            stap_pkg::REG_DEPTH:
                prdata = stap_pkg::PDATA_W'(cfg_reg.depth);
            stap_pkg::REG_LFO_SHAPE:
                prdata = stap_pkg::PDATA_W'(cfg_reg.lfo_shape);
            stap_pkg::REG_GAIN_MODE:
                prdata = stap_pkg::PDATA_W'(cfg_reg.gain_mode);
            default:
                prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/stap_lfo.sv -----
// phase accumulator and lfo waveform generator
`default_nettype none

module stap_lfo #(
    parameter int PHASE_WIDTH = 24
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          advance,
    input  wire logic [stap_pkg::STEP_W-1:0]   phase_step,
    input  wire stap_pkg::lfo_shape_t          lfo_shape,
    output stap_pkg::gain_t                    lfo
);

    logic [PHASE_WIDTH-1:0]            phase_acc_reg;
    logic [PHASE_WIDTH-1:0]            phase_acc_next;
    logic [15:0]                       p16;
    logic [stap_pkg::SINE_ADDR_W-1:0]  sine_idx;
    stap_pkg::gain_t                   centered;
    stap_pkg::gain_t                   mag;

    assign p16      = phase_acc_reg[PHASE_WIDTH-1 -: 16];
    assign sine_idx = phase_acc_reg[PHASE_WIDTH-1 -: stap_pkg::SINE_ADDR_W];
    assign phase_acc_next = phase_acc_reg + PHASE_WIDTH'(phase_step);

    // phase wraps modulo the accumulator width
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_acc_reg <= '0;
        else if (advance)
            phase_acc_reg <= phase_acc_next;
    end

    // waveform select
    always_comb
    begin
        centered = stap_pkg::gain_t'({2'b00, p16}) - stap_pkg::Q15_ONE;
        mag      = (centered < 0) ? -centered : centered;
        case (lfo_shape)
            stap_pkg::SHAPE_SINE:
                lfo = stap_pkg::gain_t'(stap_pkg::SINE_LUT[sine_idx]);
            stap_pkg::SHAPE_SQUARE:
                lfo = p16[15] ? -stap_pkg::Q15_ONE : stap_pkg::Q15_ONE;
            stap_pkg::SHAPE_SAW:
                lfo = centered;
            stap_pkg::SHAPE_TRIANGLE:
                lfo = stap_pkg::Q15_ONE - (mag <<< 1);
            default:
                lfo = centered;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/stap_lane.sv -----
// one channel lane: tremolo, pan or combined gain, then scale and saturate the sample
`default_nettype none

module stap_lane #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire logic                           clk,
    input  wire stap_pkg::lane_ctrl_t           ctrl,
    input  wire logic signed [SAMPLE_WIDTH-1:0] sample,
    input  wire stap_pkg::gain_t                trem,
    input  wire stap_pkg::gain_t                pan,
    output logic signed [SAMPLE_WIDTH-1:0]      scaled
);

    localparam int PW = SAMPLE_WIDTH + 18;
    localparam logic signed [PW-1:0] SAT_HI = PW'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1);
    localparam logic signed [PW-1:0] SAT_LO = ~SAT_HI;

    logic signed [35:0]   mix_prod;
    logic signed [35:0]   mix_rnd;
    stap_pkg::gain_t      gain_next;
    stap_pkg::gain_t      gain_reg;
    logic signed [PW-1:0] out_prod;
    logic signed [PW-1:0] out_rnd;

    // tremolo times pan, rounded back to q15
    assign mix_prod = trem * pan;
    assign mix_rnd  = (mix_prod + 36'sd16384) >>> 15;

    always_comb
    begin
        case (ctrl.mode)
            stap_pkg::MODE_TREMOLO: gain_next = trem;
            stap_pkg::MODE_PAN:     gain_next = pan;
            default:                gain_next = stap_pkg::gain_t'(mix_rnd[17:0]);
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mix_en)
            gain_reg <= gain_next;
    end

    // sample times gain, round half up, clamp
    assign out_prod = sample * gain_reg;
    assign out_rnd  = (out_prod + PW'(16384)) >>> 15;

    always_comb
    begin
        if (out_rnd > SAT_HI)
            scaled = SAT_HI[SAMPLE_WIDTH-1:0];
        else if (out_rnd < SAT_LO)
            scaled = SAT_LO[SAMPLE_WIDTH-1:0];
        else
            scaled = out_rnd[SAMPLE_WIDTH-1:0];
    end

endmodule

`default_nettype wire

// ----- rtl/stereo_tremolo_autopan.sv -----
// top level of the stereo tremolo / auto-pan block
// Each accepted stereo pair passes through IDLE, GAIN, MIX and SCALE: the
// accept cycle samples the lfo and depth, GAIN forms the tremolo and pan gains,
// MIX has the two lanes combine them, and SCALE has them scale and saturate
// into the output register once free; three dependent multiplies set this chain.
// One pair is processed at a time; the next pair is taken as soon as the
// finished result sits in the output register, even while it waits to be read.
// The phase accumulator advances by phase_step after every pair. Registers are
// written over apb and should only change while no pair is in flight.
`default_nettype none

module stereo_tremolo_autopan #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int PHASE_WIDTH  = 24
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    stap_in_if.sink                              din,
    stap_out_if.source                           dout,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [stap_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [stap_pkg::PDATA_W-1:0]    pwdata,
    output logic      [stap_pkg::PDATA_W-1:0]    prdata,
    output logic                                 pready
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_GAIN  = 4'b0010,
        ST_MIX   = 4'b0100,
        ST_SCALE = 4'b1000
    } state_t;

    state_t                          state_reg;
    state_t                          state_next;
    stap_pkg::cfg_t                  cfg;
    stap_pkg::gain_t                 lfo;
    stap_pkg::lane_ctrl_t            lane_ctrl;
    logic                            accept;
    logic                            out_free;
    logic                            out_load;
    logic signed [SAMPLE_WIDTH-1:0]  left_s_reg;
    logic signed [SAMPLE_WIDTH-1:0]  right_s_reg;
    stap_pkg::gain_t                 lfo_reg;
    logic [15:0]                     d_reg;
    stap_pkg::gain_t                 d_s;
    stap_pkg::gain_t                 trem_sum;
    logic signed [35:0]              trem_prod;
    logic signed [35:0]              trem_rnd;
    logic signed [35:0]              half_prod;
    logic signed [35:0]              half_rnd;
    stap_pkg::gain_t                 trem_next;
    stap_pkg::gain_t                 half_next;
    stap_pkg::gain_t                 trem_reg;
    stap_pkg::gain_t                 half_reg;
    stap_pkg::gain_t                 pan_left;
    stap_pkg::gain_t                 pan_right;
    logic signed [SAMPLE_WIDTH-1:0]  left_scaled;
    logic signed [SAMPLE_WIDTH-1:0]  right_scaled;
    logic signed [SAMPLE_WIDTH-1:0]  left_out_reg;
    logic signed [SAMPLE_WIDTH-1:0]  right_out_reg;
    logic                            out_valid_reg;

    // configuration registers
    stap_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // lfo, advanced once per accepted item
    stap_lfo #(
        .PHASE_WIDTH (PHASE_WIDTH)
    ) u_lfo (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (accept),
        .phase_step (cfg.phase_step),
        .lfo_shape  (cfg.lfo_shape),
        .lfo        (lfo)
    );

    // handshake and sequencer
    assign din.ready = (state_reg == ST_IDLE);
    assign accept    = din.valid && (state_reg == ST_IDLE);
    assign out_free  = !out_valid_reg || dout.ready;
    assign out_load  = (state_reg == ST_SCALE) && out_free;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (din.valid) state_next = ST_GAIN;
            ST_GAIN:  state_next = ST_MIX;
            ST_MIX:   state_next = ST_SCALE;
            ST_SCALE: if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // capture the pair, lfo value and depth on accept
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            left_s_reg  <= din.left_in;
            right_s_reg <= din.right_in;
            lfo_reg     <= lfo;
            d_reg       <= stap_pkg::DEPTH_LUT[cfg.depth];
        end
    end

    // shared gain stage: tremolo gain and pan half-swing
    assign d_s       = stap_pkg::gain_t'({2'b00, d_reg});
    assign trem_sum  = stap_pkg::Q15_ONE + lfo_reg;
    assign trem_prod = d_s * trem_sum;
    assign trem_rnd  = (trem_prod + 36'sd32768) >>> 16;
    assign half_prod = d_s * lfo_reg;
    assign half_rnd  = (half_prod + 36'sd32768) >>> 16;
    assign trem_next = stap_pkg::Q15_ONE - stap_pkg::gain_t'(trem_rnd[17:0]);
    assign half_next = stap_pkg::gain_t'(half_rnd[17:0]);

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_GAIN)
        begin
            trem_reg <= trem_next;
            half_reg <= half_next;
        end
    end

    assign pan_left  = stap_pkg::Q15_ONE - half_reg;
    assign pan_right = stap_pkg::Q15_ONE + half_reg;

    assign lane_ctrl.mix_en = (state_reg == ST_MIX);
    assign lane_ctrl.mode   = cfg.gain_mode;

    // left and right lanes
    stap_lane #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_lane_left (
        .clk    (clk),
        .ctrl   (lane_ctrl),
        .sample (left_s_reg),
        .trem   (trem_reg),
        .pan    (pan_left),
        .scaled (left_scaled)
    );

    stap_lane #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_lane_right (
        .clk    (clk),
        .ctrl   (lane_ctrl),
        .sample (right_s_reg),
        .trem   (trem_reg),
        .pan    (pan_right),
        .scaled (right_scaled)
    );

    // merge the lanes into the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (dout.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            left_out_reg  <= left_scaled;
            right_out_reg <= right_scaled;
        end
    end

    assign dout.valid     = out_valid_reg;
    assign dout.left_out  = left_out_reg;
    assign dout.right_out = right_out_reg;

endmodule

`default_nettype wire

// ----- rtl/stap_checker.sv -----
// port-level checks for the stereo tremolo / auto-pan block, bound to the top level
`default_nettype none

module stap_checker #(
    parameter int SAMPLE_WIDTH = 16
) (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           in_valid,
    input wire logic                           in_ready,
    input wire logic                           out_valid,
    input wire logic                           out_ready,
    input wire logic signed [SAMPLE_WIDTH-1:0] left_out,
    input wire logic signed [SAMPLE_WIDTH-1:0] right_out,
    input wire logic                           pready
);

    // a stalled result holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(left_out) && $stable(right_out))
    else $error("stalled result changed");

    // an accepted item keeps the input closed while the sequencer is in GAIN and MIX
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("input reopened before the item finished");

    // a new result only appears as an item finishes
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready && !$past(in_ready))
    else $error("result appeared with no item in flight");

    // the register port never waits
    assert property (@(posedge clk) disable iff (!rst_n)
        pready)
    else $error("pready dropped");

endmodule

bind stereo_tremolo_autopan stap_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_stap_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (din.valid),
    .in_ready  (din.ready),
    .out_valid (dout.valid),
    .out_ready (dout.ready),
    .left_out  (dout.left_out),
    .right_out (dout.right_out),
    .pready    (pready)
);

`default_nettype wire

// ----- dv/stereo_tremolo_autopan_test.sv -----
// self-checking testbench for the stereo tremolo / auto-pan block
module stereo_tremolo_autopan_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SW            = 16;
    localparam int PW            = 24;
    localparam int TABLE_BITS    = 8;
    localparam int CLK_PERIOD    = 10;
    localparam int QUIET_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int RANDOM_PHASES = 22;

    typedef logic signed [SW-1:0] sample_t;

    typedef struct packed {
        sample_t left;
        sample_t right;
    } pair_t;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [stap_pkg::CFG_ADDR_W-1:0] paddr;
    logic [stap_pkg::PDATA_W-1:0]    pwdata;
    logic [stap_pkg::PDATA_W-1:0]    prdata;
    logic                            pready;

    stap_in_if  #(.SAMPLE_WIDTH(SW)) din_if ();
    stap_out_if #(.SAMPLE_WIDTH(SW)) dout_if ();

    stereo_tremolo_autopan #(
        .SAMPLE_WIDTH(SW),
        .PHASE_WIDTH (PW)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .din    (din_if),
        .dout   (dout_if),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    // shadow of the registers and the lfo phase
    logic [stap_pkg::STEP_W-1:0]  lfo_step;
    logic [stap_pkg::DEPTH_W-1:0] lfo_depth;
    stap_pkg::lfo_shape_t         lfo_shape;
    logic [1:0]                   mix_mode;
    logic [PW-1:0]                lfo_phase;

    pair_t pending_pairs [$];
    pair_t scaled_pairs [$];
    pair_t next_pair;
    pair_t want_pair;

    bit no_idle;
    int gap_left;
    int stall_left;
    int quiet_cycles;
    int fail_count;
    int pairs_sent;
    int pairs_checked;
    int settings_done;

    always #(CLK_PERIOD / 2) clk = ~clk;

    // rounding shift, half toward plus infinity
    function automatic longint round_half(input longint v, input int n);
        return (v + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    // Q15 sine for table entry k from a Q30 Taylor series
    function automatic longint sine_q15(input int unsigned k);
        longint unsigned divs [6] = '{156, 110, 72, 42, 20, 6};
        longint unsigned cyc;
        longint unsigned ang;
        longint unsigned ang2;
        longint unsigned acc;
        longint unsigned prod;
        bit              lower;
        cyc = 64'(k) << (32 - TABLE_BITS);
        lower = (cyc >= 64'h8000_0000);
        if (lower)
            cyc = cyc - 64'h8000_0000;
        if (cyc > 64'h4000_0000)
            cyc = 64'h8000_0000 - cyc;
        ang  = (cyc * 64'd6746518852) >> 32;
        ang2 = (ang * ang) >> 30;
        acc  = 64'd1 << 30;
        foreach (divs[i])
            acc = (64'd1 << 30) - ((ang2 * acc) >> 30) / divs[i];
        prod = (ang * acc) >> 30;
        prod = (prod + 64'd16384) >> 15;
        if (prod > 64'd32767)
            prod = 64'd32767;
        return lower ? -longint'(prod) : longint'(prod);
    endfunction

    // lfo level in Q15 at the current phase
    function automatic longint lfo_level();
        longint p16;
        longint span;
        p16 = longint'(lfo_phase >> (PW - 16));
        case (lfo_shape)
            stap_pkg::SHAPE_SINE:
                return sine_q15(int'(lfo_phase >> (PW - TABLE_BITS)));
            stap_pkg::SHAPE_SQUARE:
                return (p16 < 32768) ? 32768 : -32768;
            stap_pkg::SHAPE_SAW:
                return p16 - 32768;
            default:
            begin
                span = p16 - 32768;
                if (span < 0)
                    span = -span;
                return 32768 - 2 * span;
            end
        endcase
    endfunction

    // sample times Q15 gain, saturated
    function automatic sample_t scale_sample(input sample_t s, input longint g);
        longint y;
        y = round_half(longint'(s) * g, 15);
        if (y > 32767)
            y = 32767;
        if (y < -32768)
            y = -32768;
        return sample_t'(y);
    endfunction

    // scaled pair for one accepted item, then the phase moves on
    task automatic apply_gain(input pair_t in_pair);
        longint lvl;
        longint d;
        longint trem;
        longint half;
        longint gl;
        longint gr;
        pair_t  res;
        lvl  = lfo_level();
        d    = (longint'(lfo_depth) * 32768 + 127) / 255;
        trem = 32768 - round_half(d * (32768 + lvl), 16);
        half = round_half(d * lvl, 16);
        case (mix_mode)
            stap_pkg::MODE_TREMOLO:
            begin
                gl = trem;
                gr = trem;
            end
            stap_pkg::MODE_PAN:
            begin
                gl = 32768 - half;
                gr = 32768 + half;
            end
            // both, and the unused code behaves the same
            default:
            begin
                gl = round_half(trem * (32768 - half), 15);
                gr = round_half(trem * (32768 + half), 15);
            end
        endcase
        res.left  = scale_sample(in_pair.left, gl);
        res.right = scale_sample(in_pair.right, gr);
        scaled_pairs.push_back(res);
        lfo_phase = lfo_phase + PW'(lfo_step);
    endtask

    // apb write: setup cycle, access cycle
    task automatic reg_write(input stap_pkg::reg_idx_t idx,
                             input logic [stap_pkg::PDATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            stap_pkg::REG_PHASE_STEP: lfo_step  = value[stap_pkg::STEP_W-1:0];
            stap_pkg::REG_DEPTH:      lfo_depth = value[stap_pkg::DEPTH_W-1:0];
            stap_pkg::REG_LFO_SHAPE:  lfo_shape = stap_pkg::lfo_shape_t'(value[1:0]);
            default:                  mix_mode  = value[1:0];
        endcase
        @(negedge clk);
    endtask

    // all four registers, junk in the unused upper bits
    task automatic set_lfo(input logic [stap_pkg::STEP_W-1:0] step,
                           input logic [stap_pkg::DEPTH_W-1:0] dep,
                           input logic [1:0] shape, input logic [1:0] mode);
        reg_write(stap_pkg::REG_PHASE_STEP, ($urandom() << stap_pkg::STEP_W) | step);
        reg_write(stap_pkg::REG_DEPTH, ($urandom() << stap_pkg::DEPTH_W) | dep);
        reg_write(stap_pkg::REG_LFO_SHAPE, ($urandom() << 2) | shape);
        reg_write(stap_pkg::REG_GAIN_MODE, ($urandom() << 2) | mode);
        settings_done++;
    endtask

    task automatic push_pair(input sample_t l, input sample_t r);
        pair_t p;
        p.left  = l;
        p.right = r;
        pending_pairs.push_back(p);
    endtask

    function automatic sample_t draw_sample();
        sample_t corner [5] = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF, 16'sh0001};
        if ($urandom_range(0, 5) == 0)
            return corner[$urandom_range(0, 4)];
        return sample_t'($urandom());
    endfunction

    // wait until every pair is sent and checked, then let the pipeline settle
    task automatic drain();
        while (pending_pairs.size() != 0 || din_if.valid || scaled_pairs.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // input driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            din_if.valid <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            // item taken at this edge goes through the gain model
            if (din_if.valid && din_if.ready)
            begin
                apply_gain({din_if.left_in, din_if.right_in});
                pairs_sent++;
            end
            // launch the next item once the slot is free and the gap is over
            if (!din_if.valid || din_if.ready)
            begin
                if (gap_left == 0 && pending_pairs.size() != 0)
                begin
                    next_pair = pending_pairs.pop_front();
                    din_if.valid    <= 1'b1;
                    din_if.left_in  <= next_pair.left;
                    din_if.right_in <= next_pair.right;
                    gap_left = no_idle ? 0 : $urandom_range(0, 3);
                end
                else
                begin
                    din_if.valid <= 1'b0;
                    if (gap_left > 0)
                        gap_left--;
                end
            end
        end
    end

    // output monitor and checker
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            dout_if.ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (dout_if.valid && dout_if.ready)
            begin
                if (scaled_pairs.size() == 0)
                begin
                    $error("unexpected result item: left_out %0d right_out %0d",
                           dout_if.left_out, dout_if.right_out);
                    fail_count++;
                end
                else
                begin
                    want_pair = scaled_pairs.pop_front();
                    if (dout_if.left_out !== want_pair.left)
                    begin
                        $error("left_out: expected %0d, actual %0d",
                               want_pair.left, dout_if.left_out);
                        fail_count++;
                    end
                    if (dout_if.right_out !== want_pair.right)
                    begin
                        $error("right_out: expected %0d, actual %0d",
                               want_pair.right, dout_if.right_out);
                        fail_count++;
                    end
                    pairs_checked++;
                end
                stall_left = no_idle ? 0 : $urandom_range(0, 3);
            end
            if (stall_left > 0)
            begin
                dout_if.ready <= 1'b0;
                stall_left--;
            end
            else
                dout_if.ready <= 1'b1;
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if (!rst_n || psel || (din_if.valid && din_if.ready) || (dout_if.valid && dout_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("stereo_tremolo_autopan_test: FAIL");
            $finish;
        end
    end

    // stimulus sequence
    initial
    begin
        din_if.valid    = 1'b0;
        din_if.left_in  = '0;
        din_if.right_in = '0;
        dout_if.ready   = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        lfo_step        = stap_pkg::PHASE_STEP_RST;
        lfo_depth       = stap_pkg::DEPTH_RST;
        lfo_shape       = stap_pkg::SHAPE_SINE;
        mix_mode        = stap_pkg::MODE_TREMOLO;
        lfo_phase       = '0;
        no_idle         = 1'b0;
        fail_count      = 0;
        pairs_sent      = 0;
        pairs_checked   = 0;
        settings_done   = 0;
        rst_n           = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset values of the registers
        push_pair(16'sh7FFF, 16'sh8000);
        push_pair(16'sh8000, 16'sh7FFF);
        push_pair(16'sh0000, 16'sh0000);
        push_pair(16'sh0001, 16'shFFFF);
        drain();

        // all ones written: fields masked, square, pan at full depth saturates
        reg_write(stap_pkg::REG_PHASE_STEP, 32'hFFFF_FFFF);
        reg_write(stap_pkg::REG_DEPTH, 32'hFFFF_FFFF);
        reg_write(stap_pkg::REG_LFO_SHAPE, 32'hFFFF_FFFD);
        reg_write(stap_pkg::REG_GAIN_MODE, 32'hFFFF_FFFD);
        settings_done++;
        push_pair(16'sh7FFF, 16'sh7FFF);
        push_pair(16'sh8000, 16'sh8000);
        push_pair(16'sh4000, 16'shC000);
        push_pair(16'sh7FFF, 16'sh8000);
        push_pair(16'sh0000, 16'shFFFF);
        drain();

        // zero step and zero depth: pass through
        set_lfo('0, '0, stap_pkg::SHAPE_SINE, stap_pkg::MODE_TREMOLO);
        push_pair(16'sh7FFF, 16'sh8000);
        push_pair(16'sh1234, -16'sh1234);
        push_pair(16'shFFFF, 16'sh0001);
        drain();

        // quarter-cycle step, saw, both gains
        set_lfo(24'h40_0000, 8'hFF, stap_pkg::SHAPE_SAW, stap_pkg::MODE_BOTH);
        push_pair(16'sh7FFF, 16'sh7FFF);
        push_pair(16'sh8000, 16'sh8000);
        push_pair(16'sh7FFF, 16'sh8000);
        push_pair(16'sh6000, 16'shA000);
        push_pair(16'sh0001, 16'sh0001);
        drain();

        // triangle with the unused gain mode code
        set_lfo(24'h15_5555, 8'd200, stap_pkg::SHAPE_TRIANGLE, 2'd3);
        push_pair(16'sh7FFF, 16'sh8000);
        push_pair(16'sh8000, 16'sh7FFF);
        push_pair(16'sh2AAA, -16'sh2AAA);
        push_pair(16'shFFFF, 16'sh0000);
        drain();

        // random settings, each with a run of random items
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            logic [stap_pkg::STEP_W-1:0]  step;
            logic [stap_pkg::DEPTH_W-1:0] dep;
            int                           n_items;
            case ($urandom_range(0, 5))
                0:       step = '0;
                1:       step = '1;
                2, 3:    step = stap_pkg::STEP_W'($urandom_range(0, 65535));
                default: step = stap_pkg::STEP_W'($urandom());
            endcase
            case ($urandom_range(0, 3))
                0:       dep = '0;
                1:       dep = '1;
                default: dep = stap_pkg::DEPTH_W'($urandom());
            endcase
            set_lfo(step, dep, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
            no_idle = ($urandom_range(0, 4) == 0);
            n_items = $urandom_range(40, 60);
            for (int i = 0; i < n_items; i++)
                push_pair(draw_sample(), draw_sample());
            drain();
        end

        $display("%0d sample pairs sent and %0d checked over %0d register settings",
                 pairs_sent, pairs_checked, settings_done);
        $display("all lfo shapes and gain modes, depth and step extremes, with random stalls");
        if (fail_count == 0)
            $display("stereo_tremolo_autopan_test: PASS");
        else
            $display("stereo_tremolo_autopan_test: FAIL");
        $finish;
    end

endmodule
